/* rtl/core/fsd_pkg.sv */
// Package for the feeder stall detector: transfer payload types, mode encoding,
// configuration register indexes and reset values.
// No dependencies.
package fsd_pkg;

  // Stall state machine encoding
  typedef enum logic [1:0] {
    MODE_NORMAL     = 2'd0,
    MODE_STALLING   = 2'd1,
    MODE_RECOVERING = 2'd2
  } mode_t;

  // Configuration register indexes
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] CFG_FILTER_ALPHA     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPEED_THRESHOLD  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_TORQUE_THRESHOLD = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_STALL_TIME_MS    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_RECOVER_TIME_MS  = 3'd4;

  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values
  localparam logic [15:0] FILTER_ALPHA_RST     = 16'd3277;
  localparam logic [14:0] SPEED_THRESHOLD_RST  = 15'd26;
  localparam logic [14:0] TORQUE_THRESHOLD_RST = 15'd512;
  localparam logic [15:0] STALL_TIME_MS_RST    = 16'd500;
  localparam logic [15:0] RECOVER_TIME_MS_RST  = 16'd500;

  // Input transfer payload
  typedef struct packed {
    logic signed [15:0] motor_speed;
    logic signed [15:0] motor_torque;
    logic [31:0]        now_ms;
    logic               force_reverse;
  } in_item_t;

  // Result transfer payload
  typedef struct packed {
    logic [1:0]         mode;
    logic               probably_blocked;
    logic               reverse_drive;
    logic signed [15:0] smoothed_speed;
    logic signed [15:0] smoothed_torque;
  } out_item_t;

  // Thresholds and timers handed to the stall state machine
  typedef struct packed {
    logic [14:0] speed_threshold;
    logic [14:0] torque_threshold;
    logic [15:0] stall_time_ms;
    logic [15:0] recover_time_ms;
  } stall_cfg_t;

endpackage

/* rtl/core/feeder_stall_detector.sv */
// Feeder stall detector top level: handshake pipeline, configuration registers,
// filters and stall state machine. Depends on fsd_pkg, fsd_lowpass, fsd_stall_fsm.
//
//   Port group  Direction  Handshake        Payload
//   in_*        input      valid/ready      fsd_pkg::in_item_t
//   out_*       output     valid/ready      fsd_pkg::out_item_t
//   cfg_*       input      write enable     index 3 bits, data 16 bits
//
// One item per cycle sustained while the result register is free or being taken;
// three register stages (input, filter, result) lie between an input transfer and
// its valid result. The rate is set by the filter update loop, one multiply-add
// per advancing cycle. Synchronous active-low reset restores register defaults
// and clears filters and mode. All stages hold while a result waits.
module feeder_stall_detector (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  fsd_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output fsd_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [fsd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [fsd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic [15:0]         alpha_r;
  fsd_pkg::stall_cfg_t cfg_r;

  logic                advance;
  logic                a_valid_r;
  fsd_pkg::in_item_t   a_item_r;
  logic                b_valid_r;
  logic [31:0]         b_now_r;
  logic                b_force_r;
  logic                out_valid_r;
  fsd_pkg::out_item_t  out_r;

  logic signed [31:0]  speed_filt;
  logic signed [31:0]  torque_filt;
  logic signed [15:0]  speed_q8;
  logic signed [15:0]  torque_q8;
  fsd_pkg::out_item_t  fsm_result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r                <= fsd_pkg::FILTER_ALPHA_RST;
      cfg_r.speed_threshold  <= fsd_pkg::SPEED_THRESHOLD_RST;
      cfg_r.torque_threshold <= fsd_pkg::TORQUE_THRESHOLD_RST;
      cfg_r.stall_time_ms    <= fsd_pkg::STALL_TIME_MS_RST;
      cfg_r.recover_time_ms  <= fsd_pkg::RECOVER_TIME_MS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        fsd_pkg::CFG_FILTER_ALPHA:     alpha_r                <= cfg_wdata;
        fsd_pkg::CFG_SPEED_THRESHOLD:  cfg_r.speed_threshold  <= cfg_wdata[14:0];
        fsd_pkg::CFG_TORQUE_THRESHOLD: cfg_r.torque_threshold <= cfg_wdata[14:0];
        fsd_pkg::CFG_STALL_TIME_MS:    cfg_r.stall_time_ms    <= cfg_wdata;
        fsd_pkg::CFG_RECOVER_TIME_MS:  cfg_r.recover_time_ms  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Whole pipe moves while the result register is free or being taken
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = advance;

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      a_valid_r   <= in_valid;
      b_valid_r   <= a_valid_r;
      out_valid_r <= b_valid_r;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (advance) begin
      if (in_valid) begin
        a_item_r <= in_data;
      end
      if (a_valid_r) begin
        b_now_r   <= a_item_r.now_ms;
        b_force_r <= a_item_r.force_reverse;
      end
      if (b_valid_r) begin
        out_r <= fsm_result;
      end
    end
  end

  // Filters update as the item moves into the second stage
  fsd_lowpass u_speed_lp (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (advance && a_valid_r),
    .alpha   (alpha_r),
    .x       (a_item_r.motor_speed),
    .filt    (speed_filt),
    .filt_q8 (speed_q8)
  );

  fsd_lowpass u_torque_lp (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (advance && a_valid_r),
    .alpha   (alpha_r),
    .x       (a_item_r.motor_torque),
    .filt    (torque_filt),
    .filt_q8 (torque_q8)
  );

  // State machine steps as the item moves into the result register
  fsd_stall_fsm u_fsm (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (advance && b_valid_r),
    .cfg           (cfg_r),
    .speed_filt    (speed_filt),
    .torque_filt   (torque_filt),
    .now_ms        (b_now_r),
    .force_reverse (b_force_r),
    .result        (fsm_result)
  );

  assign out_valid = out_valid_r;

  // Result register drives the output payload
  always_comb begin
    out_data = out_r;
  end

  // Cross-check of the filter's Q7.8 tap against the value handed to the result
  a_tap: assert property (@(posedge clk) disable iff (!rst_n)
    advance && b_valid_r |=> out_r.smoothed_speed == $past(speed_q8)
      && out_r.smoothed_torque == $past(torque_q8))
    else $error("smoothed value mismatch");

endmodule

/* rtl/core/fsd_lowpass.sv */
// First-order low-pass filter, f += alpha*(x - f), state held in Q7.24.
// One update per enabled cycle. Depends on nothing outside this file.
module fsd_lowpass (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic [15:0]        alpha,
  input  logic signed [15:0] x,
  output logic signed [31:0] filt,
  output logic signed [15:0] filt_q8
);

  logic signed [31:0] filt_r;
  logic signed [31:0] filt_nxt;
  logic signed [32:0] x24;
  logic signed [32:0] diff;
  logic signed [49:0] prod;
  logic signed [32:0] step;
  logic signed [32:0] sum;

  // Difference is exact in 33 bits; product floors through the arithmetic shift
  assign x24      = {x[15], x, 16'h0000};
  assign diff     = x24 - {filt_r[31], filt_r};
  assign prod     = $signed({1'b0, alpha}) * diff;
  assign step     = prod[48:16];
  assign sum      = {filt_r[31], filt_r} + step;
  // Result always lies between old value and x24, so it fits 32 bits
  assign filt_nxt = sum[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r <= '0;
    end else if (en) begin
      filt_r <= filt_nxt;
    end
  end

  assign filt    = filt_r;
  // Floor to Q7.8
  assign filt_q8 = filt_r[31:16];

endmodule

/* rtl/core/fsd_stall_fsm.sv */
// Blocked detection on the filtered values and the normal/stalling/recovering
// state machine with its entry time stamp. Depends on fsd_pkg.
module fsd_stall_fsm (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  fsd_pkg::stall_cfg_t cfg,
  input  logic signed [31:0] speed_filt,
  input  logic signed [31:0] torque_filt,
  input  logic [31:0]        now_ms,
  input  logic               force_reverse,
  output fsd_pkg::out_item_t result
);

  fsd_pkg::mode_t mode_r;
  fsd_pkg::mode_t mode_nxt;
  logic [31:0]    entry_r;
  logic [31:0]    entry_nxt;
  logic [31:0]    speed_mag;
  logic [31:0]    torque_mag;
  logic [31:0]    speed_lim;
  logic [31:0]    torque_lim;
  logic [31:0]    elapsed;
  logic           blocked;
  logic           stall_expired;
  logic           recover_expired;

  // Magnitudes against thresholds scaled to Q7.24
  assign speed_mag  = speed_filt[31]  ? 32'(-speed_filt)  : 32'(speed_filt);
  assign torque_mag = torque_filt[31] ? 32'(-torque_filt) : 32'(torque_filt);
  assign speed_lim  = {1'b0, cfg.speed_threshold, 16'h0000};
  assign torque_lim = {1'b0, cfg.torque_threshold, 16'h0000};
  assign blocked    = (speed_mag < speed_lim) && (torque_mag > torque_lim);

  // Time since last mode change, wrapping
  assign elapsed         = now_ms - entry_r;
  assign stall_expired   = elapsed > {16'h0000, cfg.stall_time_ms};
  assign recover_expired = elapsed > {16'h0000, cfg.recover_time_ms};

  // Next state
  always_comb begin
    mode_nxt  = mode_r;
    entry_nxt = entry_r;
    unique case (mode_r)
      fsd_pkg::MODE_NORMAL: begin
        if (blocked) begin
          mode_nxt  = fsd_pkg::MODE_STALLING;
          entry_nxt = now_ms;
        end
      end
      fsd_pkg::MODE_STALLING: begin
        if (!blocked) begin
          mode_nxt  = fsd_pkg::MODE_NORMAL;
          entry_nxt = now_ms;
        end else if (stall_expired) begin
          mode_nxt  = fsd_pkg::MODE_RECOVERING;
          entry_nxt = now_ms;
        end
      end
      fsd_pkg::MODE_RECOVERING: begin
        if (recover_expired) begin
          mode_nxt  = fsd_pkg::MODE_NORMAL;
          entry_nxt = now_ms;
        end
      end
      default: begin
        mode_nxt = fsd_pkg::MODE_NORMAL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= fsd_pkg::MODE_NORMAL;
      entry_r <= '0;
    end else if (en) begin
      mode_r  <= mode_nxt;
      entry_r <= entry_nxt;
    end
  end

  // Result for this step
  always_comb begin
    result.mode             = mode_nxt;
    result.probably_blocked = blocked;
    result.reverse_drive    = force_reverse || (mode_nxt == fsd_pkg::MODE_RECOVERING);
    result.smoothed_speed   = speed_filt[31:16];
    result.smoothed_torque  = torque_filt[31:16];
  end

  // Normal can only move on to stalling
  a_normal_exit: assert property (@(posedge clk) disable iff (!rst_n)
    en && mode_r == fsd_pkg::MODE_NORMAL
      |=> mode_r == fsd_pkg::MODE_NORMAL || mode_r == fsd_pkg::MODE_STALLING)
    else $error("normal left for recovering");

  // Recovering never drops back to stalling
  a_recover_exit: assert property (@(posedge clk) disable iff (!rst_n)
    en && mode_r == fsd_pkg::MODE_RECOVERING |=> mode_r != fsd_pkg::MODE_STALLING)
    else $error("recovering went to stalling");

  // No step, no state change
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(mode_r) && $stable(entry_r))
    else $error("state moved without a step");

  // Entry time only moves with a mode change
  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    en && mode_nxt == mode_r |=> $stable(entry_r))
    else $error("entry time changed without mode change");

endmodule
